// ----- design/mdrf_pkg.sv -----
// shared types and constants for the median decimating ring fifo
// no dependencies; imported by every module of the block
package mdrf_pkg;

  localparam int DATA_W = 32;
  localparam int BIN_COUNT_W = 5;
  localparam int RING_SIZE_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam int BIN_DEPTH_DEF = 16;
  localparam int RING_DEPTH_DEF = 64;

  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = BIN_COUNT_W'(1);
  localparam logic [RING_SIZE_W-1:0] RING_SIZE_RST = RING_SIZE_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    BIN_IDLE,
    BIN_SCAN,
    BIN_PLACE,
    BIN_MED_RD,
    BIN_MED_OUT
  } bin_state_t;

  typedef struct packed {
    logic done;
    logic push;
  } bin_res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  typedef struct packed {
    logic done;
    logic ok;
  } ring_res_t;

endpackage

// ----- design/mdrf_bin.sv -----
// sorted bin: sample memory, insertion walk and median readout
// depends on mdrf_pkg
module mdrf_bin #(
  parameter int BIN_DEPTH = mdrf_pkg::BIN_DEPTH_DEF,
  localparam int FILL_W = $clog2(BIN_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [mdrf_pkg::DATA_W-1:0] sample,
  input  logic [FILL_W-1:0]           cnt,
  output mdrf_pkg::bin_res_t          res,
  output logic [mdrf_pkg::DATA_W-1:0] median
);
  import mdrf_pkg::*;

  localparam int AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;

  logic [DATA_W-1:0] mem [BIN_DEPTH];
  logic [DATA_W-1:0] rd_data;

  bin_state_t state, state_next;
  logic [AW-1:0] pos, pos_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [DATA_W-1:0] sample_q;
  logic [FILL_W-1:0] cnt_q;

  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data;
  logic [FILL_W-1:0] fill_inc, half;
  logic [AW-1:0] med_idx;
  logic scan_gt;

  assign fill_inc = (cnt_q == FILL_W'(1)) ? FILL_W'(1) : fill + FILL_W'(1);
  assign half = cnt_q >> 1;
  assign med_idx = half[AW-1:0];
  assign scan_gt = $signed(rd_data) > $signed(sample_q);
  assign median = rd_data;

  always_comb begin
    state_next = state;
    case (state)
      BIN_IDLE: begin
        if (go) begin
          state_next = (cnt == FILL_W'(1) || fill == '0) ? BIN_PLACE : BIN_SCAN;
        end
      end
      BIN_SCAN: begin
        if (!scan_gt || pos == AW'(1)) begin
          state_next = BIN_PLACE;
        end
      end
      BIN_PLACE: state_next = (fill_inc >= cnt_q) ? BIN_MED_RD : BIN_IDLE;
      BIN_MED_RD: state_next = BIN_MED_OUT;
      BIN_MED_OUT: state_next = BIN_IDLE;
      default: state_next = BIN_IDLE;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos;
    wr_data = sample_q;
    rd_en = 1'b0;
    rd_addr = pos - AW'(2);
    pos_next = pos;
    fill_next = fill;
    res = '0;
    case (state)
      BIN_IDLE: begin
        if (go) begin
          rd_en = 1'b1;
          rd_addr = fill[AW-1:0] - AW'(1);
          pos_next = (cnt == FILL_W'(1)) ? '0 : fill[AW-1:0];
        end
      end
      BIN_SCAN: begin
        if (scan_gt) begin
          wr_en = 1'b1;
          wr_data = rd_data;
          pos_next = pos - AW'(1);
          rd_en = 1'b1;
        end
      end
      BIN_PLACE: begin
        wr_en = 1'b1;
        if (fill_inc >= cnt_q) begin
          fill_next = '0;
        end else begin
          fill_next = fill_inc;
          res.done = 1'b1;
        end
      end
      BIN_MED_RD: begin
        rd_en = 1'b1;
        rd_addr = med_idx;
      end
      BIN_MED_OUT: begin
        res.done = 1'b1;
        res.push = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BIN_IDLE;
      fill <= '0;
    end else begin
      state <= state_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (state == BIN_IDLE && go) begin
      sample_q <= sample;
      cnt_q <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/mdrf_ring.sv -----
// median ring: circular memory with head and tail pointers
// depends on mdrf_pkg
module mdrf_ring #(
  parameter int RING_DEPTH = mdrf_pkg::RING_DEPTH_DEF,
  localparam int SIZE_W = $clog2(RING_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mdrf_pkg::ring_cmd_t         cmd,
  input  logic [mdrf_pkg::DATA_W-1:0] push_value,
  input  logic [SIZE_W-1:0]           size,
  output mdrf_pkg::ring_res_t         res,
  output logic [mdrf_pkg::DATA_W-1:0] pop_value
);
  import mdrf_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  logic [DATA_W-1:0] mem [RING_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0] head, tail, head_adv, tail_adv;
  logic nonempty;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p,
                                              input logic [SIZE_W-1:0] sz);
    logic [AW:0] n;
    n = {1'b0, p} + (AW+1)'(1);
    return (int'(n) >= int'(sz)) ? '0 : n[AW-1:0];
  endfunction

  assign head_adv = ring_next(head, size);
  assign tail_adv = ring_next(tail, size);
  assign nonempty = head != tail;
  assign pop_value = res.ok ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      res <= '0;
    end else begin
      res.done <= cmd.push | cmd.pop;
      res.ok <= cmd.pop & nonempty;
      if (cmd.push) begin
        head <= head_adv;
        if (head_adv == tail) begin
          tail <= tail_adv;
        end
      end else if (cmd.pop && nonempty) begin
        tail <= tail_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[head_adv] <= push_value;
    end
    if (cmd.pop && nonempty) begin
      rd_data <= mem[tail_adv];
    end
  end

endmodule

// ----- design/median_decimating_ring_fifo.sv -----
// Median decimator feeding a ring fifo. Each item is taken on start while
// busy is low; its single result appears for one cycle with done and cannot
// be held off. A write walks the sorted bin memory one entry per cycle,
// moving up each stored sample greater than the new one (at most
// BIN_DEPTH-1); there is no walk when the bin is empty or the bin count is
// one. When the bin completes, its median is read out and pushed into the
// ring. A read goes through the registered ring memory read. busy drops in
// the cycle done is shown, so the next item may start then. The user must
// write configuration through cfg_valid/cfg_ready only while no item is in
// flight; the block itself does not enforce it.
// depends on mdrf_pkg, mdrf_bin, mdrf_ring
module median_decimating_ring_fifo #(
  parameter int BIN_DEPTH = mdrf_pkg::BIN_DEPTH_DEF,
  parameter int RING_DEPTH = mdrf_pkg::RING_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode,
  input  logic signed [mdrf_pkg::DATA_W-1:0] sample_value,
  output logic                              done,
  output logic                              read_ok,
  output logic signed [mdrf_pkg::DATA_W-1:0] read_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mdrf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mdrf_pkg::*;

  localparam int FILL_W = $clog2(BIN_DEPTH + 1);
  localparam int SIZE_W = $clog2(RING_DEPTH + 1);

  logic [BIN_COUNT_W-1:0] bin_count;
  logic [RING_SIZE_W-1:0] ring_size;
  logic [FILL_W-1:0] cnt_eff;
  logic [SIZE_W-1:0] size_eff;
  logic accept, item_mode, result_now;

  bin_res_t bin_res;
  logic [DATA_W-1:0] median;
  ring_cmd_t ring_cmd;
  ring_res_t ring_res;
  logic [DATA_W-1:0] pop_value;

  assign cfg_ready = 1'b1;
  assign accept = start && !busy;

  always_comb begin
    if (bin_count == '0) begin
      cnt_eff = FILL_W'(1);
    end else if (int'(bin_count) > BIN_DEPTH) begin
      cnt_eff = FILL_W'(BIN_DEPTH);
    end else begin
      cnt_eff = FILL_W'(bin_count);
    end
  end

  always_comb begin
    if (int'(ring_size) < 2) begin
      size_eff = SIZE_W'(2);
    end else if (int'(ring_size) > RING_DEPTH) begin
      size_eff = SIZE_W'(RING_DEPTH);
    end else begin
      size_eff = SIZE_W'(ring_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= BIN_COUNT_RST;
      ring_size <= RING_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIN_COUNT: bin_count <= cfg_data[BIN_COUNT_W-1:0];
        REG_RING_SIZE: ring_size <= cfg_data[RING_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  mdrf_bin #(
    .BIN_DEPTH(BIN_DEPTH)
  ) u_bin (
    .clk(clk),
    .rst(rst),
    .go(accept && !mode),
    .sample(sample_value),
    .cnt(cnt_eff),
    .res(bin_res),
    .median(median)
  );

  assign ring_cmd.push = bin_res.done && bin_res.push;
  assign ring_cmd.pop = accept && mode;

  mdrf_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk(clk),
    .rst(rst),
    .cmd(ring_cmd),
    .push_value(median),
    .size(size_eff),
    .res(ring_res),
    .pop_value(pop_value)
  );

  assign result_now = ring_res.done || (bin_res.done && !bin_res.push);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      read_ok <= 1'b0;
      read_value <= '0;
      item_mode <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        item_mode <= mode;
      end else if (result_now) begin
        busy <= 1'b0;
      end
      done <= result_now;
      read_ok <= ring_res.ok;
      read_value <= $signed(pop_value);
    end
  end

  a_done_follows_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result beat without an item in flight");

  a_ok_only_on_read: assert property (@(posedge clk) disable iff (rst)
    done && read_ok |-> item_mode)
    else $error("median returned for a write item");

  a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    !read_ok |-> read_value == '0)
    else $error("nonzero value without a popped median");

  a_single_source: assert property (@(posedge clk) disable iff (rst)
    ring_res.done |-> !(bin_res.done && !bin_res.push))
    else $error("bin and ring finished in the same cycle");

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for median_decimating_ring_fifo: a directed table, then random phases
// keeps its own median/ring predictor, checks each done beat in order; depends on mdrf_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mdrf_pkg::*;

  localparam bit OP_WRITE = 1'b0;
  localparam bit OP_READ = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = CFG_IDX_W'(3);
  localparam int BINS = BIN_DEPTH_DEF;
  localparam int SLOTS = RING_DEPTH_DEF;
  localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    logic ok;
    logic signed [DATA_W-1:0] value;
  } median_beat_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    bit rd;
    logic signed [DATA_W-1:0] smp;
    bit typed;
    median_beat_t want;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic mode;
  logic signed [DATA_W-1:0] sample_value;
  logic done;
  logic read_ok;
  logic signed [DATA_W-1:0] read_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  median_decimating_ring_fifo DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .sample_value(sample_value),
    .done(done),
    .read_ok(read_ok),
    .read_value(read_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [DATA_W-1:0] bin_sorted [BINS];
  int unsigned bin_level = 0;
  logic signed [DATA_W-1:0] med_store [SLOTS];
  bit med_written [SLOTS];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  logic [BIN_COUNT_W-1:0] bins_reg = BIN_COUNT_RST;
  logic [RING_SIZE_W-1:0] slots_reg = RING_SIZE_RST;

  median_beat_t outputs_due [$];
  row_t script [$];
  int fail_count = 0;
  int stall_cycles = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned eff_bins();
    int unsigned b;
    b = int'(bins_reg);
    if (b == 0) return 1;
    if (b > BINS) return BINS;
    return b;
  endfunction

  function automatic int unsigned eff_slots();
    int unsigned s;
    s = int'(slots_reg);
    if (s < 2) return 2;
    if (s > SLOTS) return SLOTS;
    return s;
  endfunction

  function automatic int unsigned ring_advance(int unsigned p);
    return (p + 1 >= eff_slots()) ? 0 : p + 1;
  endfunction

  // a read must never land on a slot that was never pushed
  function automatic bit read_is_safe();
    return (wr_ptr == rd_ptr) || med_written[ring_advance(rd_ptr)];
  endfunction

  function automatic median_beat_t decimate_step(bit rd, logic signed [DATA_W-1:0] smp);
    median_beat_t res;
    int unsigned cnt;
    int unsigned pos;
    res = '0;
    cnt = eff_bins();
    if (rd == OP_WRITE) begin
      if (cnt > 1) begin
        pos = (bin_level >= BINS) ? BINS - 1 : bin_level;
        while (pos > 0 && bin_sorted[pos-1] > smp) begin
          bin_sorted[pos] = bin_sorted[pos-1];
          pos--;
        end
        bin_sorted[pos] = smp;
        bin_level++;
      end else begin
        bin_sorted[0] = smp;
        bin_level = 1;
      end
      if (bin_level >= cnt) begin
        bin_level = 0;
        wr_ptr = ring_advance(wr_ptr);
        med_store[wr_ptr] = bin_sorted[cnt/2];
        med_written[wr_ptr] = 1'b1;
        if (wr_ptr == rd_ptr) rd_ptr = ring_advance(rd_ptr);
      end
    end else if (wr_ptr != rd_ptr) begin
      rd_ptr = ring_advance(rd_ptr);
      res.ok = 1'b1;
      res.value = med_store[rd_ptr];
    end
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_item(bit rd, logic signed [DATA_W-1:0] smp);
    script.push_back('{ROW_ITEM, '0, '0, rd, smp, 1'b0, '0});
  endfunction

  function automatic void add_check(bit rd, logic signed [DATA_W-1:0] smp, bit ok,
                                    logic signed [DATA_W-1:0] val);
    script.push_back('{ROW_ITEM, '0, '0, rd, smp, 1'b1, '{ok, val}});
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    script.push_back('{ROW_REG, idx, data, 1'b0, '0, 1'b0, '0});
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (outputs_due.size() != 0) @(negedge clk);
  endtask

  task automatic send_item(bit rd, logic signed [DATA_W-1:0] smp, bit typed,
                           median_beat_t want, int gap);
    median_beat_t predicted;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    mode <= rd;
    sample_value <= smp;
    do @(posedge clk); while (busy);
    predicted = decimate_step(rd, smp);
    outputs_due.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BIN_COUNT) bins_reg = data[BIN_COUNT_W-1:0];
    else if (idx == REG_RING_SIZE) slots_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result beat checker and stall counter
  always @(posedge clk) begin
    median_beat_t want;
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done) begin
        if (outputs_due.size() == 0) begin
          $error("result beat with nothing due: read_ok %0b read_value %0d", read_ok, read_value);
          fail_count++;
        end else begin
          want = outputs_due.pop_front();
          if (read_ok !== want.ok) begin
            $error("read_ok: expected %0b, got %0b", want.ok, read_ok);
            fail_count++;
          end
          if (read_value !== want.value) begin
            $error("read_value: expected %0d, got %0d", want.value, read_value);
            fail_count++;
          end
        end
      end
      if ((start && !busy) || (cfg_valid && cfg_ready) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned rd_pct;
    bit idle_on;
    bit rd;
    logic [CFG_DATA_W-1:0] pick;
    rst = 1'b1;
    start = 1'b0;
    mode = OP_WRITE;
    sample_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_check(OP_READ, 0, 1'b0, 0);
    add_check(OP_WRITE, S_MAX, 1'b0, 0);
    add_check(OP_WRITE, S_MIN, 1'b0, 0);
    add_check(OP_READ, 0, 1'b1, S_MAX);
    add_check(OP_READ, -1, 1'b1, S_MIN);
    add_check(OP_READ, 0, 1'b0, 0);
    // even count picks the upper median
    add_reg(REG_BIN_COUNT, 4);
    add_item(OP_WRITE, 5);
    add_item(OP_WRITE, -3);
    add_item(OP_WRITE, 100);
    add_item(OP_WRITE, 0);
    add_item(OP_READ, 0);
    // bin count zero acts as one while samples are pending
    add_reg(REG_BIN_COUNT, 3);
    add_item(OP_WRITE, 7);
    add_item(OP_WRITE, 9);
    add_reg(REG_BIN_COUNT, 0);
    add_item(OP_WRITE, 42);
    add_item(OP_READ, 0);
    // bin count lowered mid-bin
    add_reg(REG_BIN_COUNT, 5);
    add_item(OP_WRITE, 1);
    add_item(OP_WRITE, 2);
    add_item(OP_WRITE, 3);
    add_reg(REG_BIN_COUNT, 2);
    add_item(OP_WRITE, 10);
    // ring shrunk below minimum with pointers past the end, writes to unused indexes
    add_reg(REG_RING_SIZE, 0);
    add_reg(REG_UNUSED_A, 7'h7f);
    add_reg(REG_UNUSED_B, 7'h55);
    add_item(OP_WRITE, -1);
    add_item(OP_WRITE, -2);
    add_item(OP_READ, 0);
    add_item(OP_READ, 0);
    // oversized values clamp to the depths
    add_reg(REG_BIN_COUNT, 7'h7f);
    add_reg(REG_RING_SIZE, 7'h7f);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) write_reg(script[i].idx, script[i].data);
      else send_item(script[i].rd, script[i].smp, script[i].typed, script[i].want,
                     $urandom_range(0, 10));
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: pick = 1;
        1: pick = 2;
        2: pick = 16;
        3: pick = 0;
        4: pick = 7'h7f;
        default: pick = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                                     : CFG_DATA_W'($urandom_range(1, 5));
      endcase
      write_reg(REG_BIN_COUNT, pick);
      case (phase)
        0: pick = 2;
        1: pick = 64;
        2: pick = 1;
        3: pick = 3;
        4: pick = 0;
        default: pick = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                                     : CFG_DATA_W'($urandom_range(2, 8));
      endcase
      write_reg(REG_RING_SIZE, pick);
      if ($urandom_range(0, 3) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_A : REG_UNUSED_B,
                  CFG_DATA_W'($urandom_range(0, 127)));
      rd_pct = $urandom_range(5, 60);
      idle_on = ($urandom_range(0, 2) != 0);
      repeat (PHASE_ITEMS) begin
        rd = ($urandom_range(0, 99) < rd_pct) ? OP_READ : OP_WRITE;
        if (rd == OP_READ && !read_is_safe()) rd = OP_WRITE;
        send_item(rd, rand_sample(), 1'b0, '0, idle_on ? $urandom_range(0, 10) : 0);
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- median_decimating_ring_fifo.f -----
design/mdrf_pkg.sv
design/mdrf_bin.sv
design/mdrf_ring.sv
design/median_decimating_ring_fifo.sv
tb/tb_top.sv
